FILE: hdl/fsd_pkg.sv
// Shared constants for the false sharing detector.
package fsd_pkg;

  localparam int ADDR_BITS_DEF  = 16;
  localparam int TID_BITS_DEF   = 16;
  localparam int LINE_SHIFT_DEF = 6;

endpackage

FILE: hdl/false_sharing_detector.sv
// False sharing detector: byte and line owner stores with read-modify-write.
// Stages s1 and out; out_valid rises the cycle after the edge that takes the beat.
// Throughput: one access per cycle while not busy; a one-entry forward path
// from the stage ahead covers back-to-back hits.
// Reset: synchronous, active low; afterwards busy stays high while both owner
// stores are swept to zero.
// The receiver cannot stall: every result appears for one cycle only.
module false_sharing_detector
  import fsd_pkg::*;
#(
  parameter int ADDR_BITS  = ADDR_BITS_DEF,
  parameter int TID_BITS   = TID_BITS_DEF,
  parameter int LINE_SHIFT = LINE_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [ADDR_BITS-1:0] in_addr,
  input  logic [TID_BITS-1:0]  in_thread_id,
  input  logic                 in_is_write,
  output logic                 out_valid,
  output logic                 out_false_sharing
);

  localparam int LINE_BITS  = ADDR_BITS - LINE_SHIFT;
  localparam int BYTE_DEPTH = 1 << ADDR_BITS;
  localparam int LINE_DEPTH = 1 << LINE_BITS;
  localparam int ENT_BITS   = TID_BITS + 1;

  typedef logic [ENT_BITS-1:0] entry_t;

  entry_t byte_mem [BYTE_DEPTH];
  entry_t line_mem [LINE_DEPTH];

  // control
  logic                 clearing_r, clearing_nxt;
  logic [ADDR_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  logic                 s1_vld_r;
  logic                 out_valid_r;
  logic                 out_fs_r;

  // payload
  logic [ADDR_BITS-1:0] s1_addr_r;
  logic [TID_BITS-1:0]  s1_tid_r;
  logic                 s1_wr_r;
  entry_t               byte_q_r, line_q_r;
  logic                 fwd_byte_r, fwd_line_r;
  entry_t               fwd_ent_r;

  logic                 accept;
  logic [LINE_BITS-1:0] in_line, s1_line;
  entry_t               s1_ent, old_byte, old_line;
  logic                 hit;

  assign busy    = clearing_r;
  assign accept  = start && !clearing_r;
  assign in_line = in_addr[ADDR_BITS-1:LINE_SHIFT];
  assign s1_line = s1_addr_r[ADDR_BITS-1:LINE_SHIFT];
  assign s1_ent  = {s1_wr_r, s1_tid_r};

  always_comb begin
    clearing_nxt = clearing_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) clearing_nxt = 1'b0;
    end
  end

  // the stage ahead writes in the cycle this beat reads, so take its entry instead
  always_comb begin
    old_byte = fwd_byte_r ? fwd_ent_r : byte_q_r;
    old_line = fwd_line_r ? fwd_ent_r : line_q_r;
    hit = (old_line != '0) && (old_line[TID_BITS] || s1_wr_r) &&
          (old_line[TID_BITS-1:0] != s1_tid_r) &&
          ((old_byte == '0) || (old_byte[TID_BITS-1:0] == s1_tid_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_fs_r    <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_vld_r    <= accept;
      out_valid_r <= s1_vld_r;
      out_fs_r    <= s1_vld_r && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r  <= in_addr;
      s1_tid_r   <= in_thread_id;
      s1_wr_r    <= in_is_write;
      fwd_byte_r <= s1_vld_r && (s1_addr_r == in_addr);
      fwd_line_r <= s1_vld_r && (s1_line == in_line);
      fwd_ent_r  <= s1_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      byte_mem[clr_cnt_r] <= '0;
    end else if (s1_vld_r) begin
      byte_mem[s1_addr_r] <= s1_ent;
    end
    if (accept) byte_q_r <= byte_mem[in_addr];
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      line_mem[clr_cnt_r[LINE_BITS-1:0]] <= '0;
    end else if (s1_vld_r) begin
      line_mem[s1_line] <= s1_ent;
    end
    if (accept) line_q_r <= line_mem[in_line];
  end

  assign out_valid         = out_valid_r;
  assign out_false_sharing = out_fs_r;

endmodule

FILE: hdl/fsd_checker.sv
// Port-level checks for the false sharing detector, bound to the top level.
module fsd_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_false_sharing
);

  // every beat taken gives exactly one result
  a_beat_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted beat without result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without accepted beat");

  a_flag_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !out_false_sharing)
    else $error("false_sharing set without strobe");

  // store sweep holds the block busy straight after reset
  a_busy_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("not busy after reset");

endmodule

bind false_sharing_detector fsd_checker u_fsd_checker (.*);

FILE: tb/sv/false_sharing_detector_test.sv
// Self-checking testbench for the false sharing detector: directed and random accesses.
module false_sharing_detector_test;
  import fsd_pkg::*;

  localparam int AW = ADDR_BITS_DEF;
  localparam int TW = TID_BITS_DEF;
  localparam int LS = LINE_SHIFT_DEF;
  localparam int LW = AW - LS;
  localparam int LINES = 1 << (AW - LS);
  localparam int RANDOM_ACCESSES = 1536;
  // clearing sweep after reset plus generous slack
  localparam int STALL_LIMIT = (1 << AW) * 4 + 1000;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic [TW-1:0] tid;
    logic          wr;
  } access_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [AW-1:0] in_addr = '0;
  logic [TW-1:0] in_thread_id = '0;
  logic          in_is_write = 1'b0;
  logic          out_valid;
  logic          out_false_sharing;

  false_sharing_detector dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_addr(in_addr),
    .in_thread_id(in_thread_id),
    .in_is_write(in_is_write),
    .out_valid(out_valid),
    .out_false_sharing(out_false_sharing)
  );

  // shadow copies of the owner stores; zero means untouched
  bit [TW:0] byte_owner [0:(1<<AW)-1];
  bit [TW:0] line_owner [0:LINES-1];

  access_t pending_accesses[$];
  bit      expected_hits[$];
  bit      beat_taken = 1'b0;
  int      idle_cycles = 0;
  int      error_count = 0;
  int      accesses_done = 0;
  int      hits_seen = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit sharing_verdict(access_t acc);
    bit [AW-LS-1:0] line;
    bit [TW:0]      entry;
    bit [TW:0]      old_line;
    bit [TW:0]      old_byte;
    bit             hit;
    line = acc.addr[AW-1:LS];
    entry = {acc.wr, acc.tid};
    old_line = line_owner[line];
    old_byte = byte_owner[acc.addr];
    line_owner[line] = entry;
    byte_owner[acc.addr] = entry;
    hit = 1'b0;
    if (old_line != '0 && (old_line[TW] || acc.wr)) begin
      if (old_line[TW-1:0] != acc.tid &&
          (old_byte == '0 || old_byte[TW-1:0] == acc.tid))
        hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic queue_access(input logic [AW-1:0] addr, input logic [TW-1:0] tid,
                              input logic wr);
    access_t acc;
    acc.addr = addr;
    acc.tid = tid;
    acc.wr = wr;
    pending_accesses.push_back(acc);
  endtask

  // driver: presents one beat at a time, with random gaps between beats
  always @(negedge clk) begin
    access_t acc;
    logic    nxt_start;
    int      gap_left;
    bit      gaps_on;
    nxt_start = start;
    if (!rst_n) begin
      nxt_start = 1'b0;
      gap_left = 0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        nxt_start = 1'b0;
      end else if (pending_accesses.size() > 0) begin
        acc = pending_accesses.pop_front();
        in_addr <= acc.addr;
        in_thread_id <= acc.tid;
        in_is_write <= acc.wr;
        nxt_start = 1'b1;
        // quiet stretches, and no gaps at all near the end
        gaps_on = pending_accesses.size() > 250 &&
                  ((pending_accesses.size() / 150) % 3 != 0);
        if (gaps_on && $urandom_range(0, 4) == 0)
          gap_left = $urandom_range(1, 7);
      end else begin
        nxt_start = 1'b0;
      end
    end
    start <= nxt_start;
  end

  // monitor: predicts on each accepted beat, checks each result strobe
  always @(posedge clk) begin
    access_t acc;
    bit      want;
    bit      taken;
    taken = rst_n && start && !busy;
    beat_taken <= taken;
    if (taken) begin
      acc.addr = in_addr;
      acc.tid = in_thread_id;
      acc.wr = in_is_write;
      expected_hits.push_back(sharing_verdict(acc));
      accesses_done++;
    end
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        $error("unexpected result: false_sharing=%0b with nothing outstanding",
               out_false_sharing);
        error_count++;
      end else begin
        want = expected_hits.pop_front();
        if (out_false_sharing !== want) begin
          $error("false_sharing mismatch: expected %0b, actual %0b", want,
                 out_false_sharing);
          error_count++;
        end
      end
      if (out_false_sharing === 1'b1) hits_seen++;
    end
    if (taken || (rst_n && out_valid)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("false_sharing_detector_test: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [AW-LS-1:0] hot_lines [4];
    logic [TW-1:0]    hot_tids [4];
    logic [AW-1:0]    addr;
    logic [TW-1:0]    tid;
    int               pick;

    // directed: line sharing, true sharing, thread zero reads, region edges
    queue_access(16'h0000, 16'h0001, 1'b1);
    queue_access(16'h0001, 16'h0002, 1'b0);
    queue_access(16'h0001, 16'h0003, 1'b0);
    queue_access(16'h0002, 16'h0003, 1'b1);
    queue_access(16'h0003, 16'h0004, 1'b0);
    queue_access(16'h0000, 16'h0005, 1'b1);
    queue_access(16'h0000, 16'h0000, 1'b0); // thread zero read clears the line entry
    queue_access(16'h0001, 16'h0006, 1'b1); // line looks untouched, byte does not
    queue_access(16'hFFFF, 16'hFFFF, 1'b1);
    queue_access(16'hFFC0, 16'h8000, 1'b0);
    queue_access(16'hFFFF, 16'hFFFF, 1'b0);
    queue_access(16'hFFFE, 16'h0000, 1'b1);
    queue_access(16'hFFFE, 16'h0000, 1'b1);
    queue_access(16'h5555, 16'hAAAA, 1'b1);
    queue_access(16'h5556, 16'h5555, 1'b0);
    queue_access(16'hAAAA, 16'h5555, 1'b1);
    queue_access(16'hAAAB, 16'hAAAA, 1'b1);
    queue_access(16'h8000, 16'h7FFF, 1'b0);
    queue_access(16'h8001, 16'h0001, 1'b0);

    // random: mostly contention on a few hot lines among a few threads
    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i % 200 == 0) begin
        foreach (hot_lines[k]) hot_lines[k] = LW'($urandom_range(0, LINES - 1));
        foreach (hot_tids[k]) hot_tids[k] = TW'($urandom_range(1, 7));
        hot_tids[3] = TW'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        addr = {hot_lines[$urandom_range(0, 3)], LS'($urandom_range(0, (1 << LS) - 1))};
        tid = hot_tids[$urandom_range(0, 3)];
      end else if (pick < 80) begin
        addr = {hot_lines[$urandom_range(0, 3)], LS'($urandom_range(0, (1 << LS) - 1))};
        tid = '0;
      end else begin
        addr = AW'($urandom);
        tid = TW'($urandom);
      end
      queue_access(addr, tid, 1'($urandom_range(0, 1)));
    end

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_accesses.size() != 0 || start || expected_hits.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d accesses, %0d of them reported as false sharing",
             accesses_done, hits_seen);
    if (error_count == 0) begin
      $display("false_sharing_detector_test: PASS");
    end else begin
      $display("false_sharing_detector_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: false_sharing_detector.f
hdl/fsd_pkg.sv
hdl/false_sharing_detector.sv
hdl/fsd_checker.sv
tb/sv/false_sharing_detector_test.sv
